/* rtl/core/gbp_pkg.sv */
// Shared types, constants and a helper function for the GIF block stream parser.
`timescale 1ns / 1ps

package gbp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] BYTE_TRAILER  = 8'h3B;
    localparam logic [7:0] BYTE_IMAGE    = 8'h2C;
    localparam logic [7:0] BYTE_EXT      = 8'h21;
    localparam logic [7:0] BYTE_GCE      = 8'hF9;
    localparam logic [7:0] BYTE_APP      = 8'hFF;
    localparam logic [7:0] BYTE_GCE_SIZE = 8'h04;
    localparam logic [7:0] BYTE_APP_SIZE = 8'h0B;
    localparam logic [7:0] BYTE_LOOP_ID  = 8'h01;

    // Event kinds reported on the output.
    localparam logic [4:0] EV_SCR_W     = 5'd0;
    localparam logic [4:0] EV_SCR_H     = 5'd1;
    localparam logic [4:0] EV_SCR_FLAGS = 5'd2;
    localparam logic [4:0] EV_GPAL      = 5'd3;
    localparam logic [4:0] EV_LEFT      = 5'd4;
    localparam logic [4:0] EV_IMG_FLAGS = 5'd8;
    localparam logic [4:0] EV_LPAL      = 5'd9;
    localparam logic [4:0] EV_MIN_CODE  = 5'd10;
    localparam logic [4:0] EV_LZW_BYTE  = 5'd11;
    localparam logic [4:0] EV_IMG_END   = 5'd12;
    localparam logic [4:0] EV_GCE_FLAGS = 5'd13;
    localparam logic [4:0] EV_DELAY     = 5'd14;
    localparam logic [4:0] EV_TRANSP    = 5'd15;
    localparam logic [4:0] EV_LOOP      = 5'd16;
    localparam logic [4:0] EV_TRAILER   = 5'd17;
    localparam logic [4:0] EV_ERROR     = 5'd18;

    localparam logic [1:0] ERR_UNKNOWN  = 2'd0;
    localparam logic [1:0] ERR_GCE_SIZE = 2'd1;
    localparam logic [1:0] ERR_GCE_TERM = 2'd2;
    localparam logic [1:0] ERR_APP_SIZE = 2'd3;

    // Byte classes worked out by the front end.
    typedef struct packed {
        logic is_zero;
        logic is_trailer;
        logic is_image;
        logic is_ext;
        logic is_app;
        logic is_gce;
        logic is_gce_size;
        logic is_app_size;
        logic is_loop_id;
    } t_class;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        t_class     cls;
    } t_front_word;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] value;
        logic [9:0]  offset;
        logic [1:0]  err;
    } t_event;

    function automatic logic [7:0] netscape_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h4E;
            3'd1: c = 8'h45;
            3'd2: c = 8'h54;
            3'd3: c = 8'h53;
            3'd4: c = 8'h43;
            3'd5: c = 8'h41;
            3'd6: c = 8'h50;
            3'd7: c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/gif_block_stream_parser.sv */
// GIF block stream parser: one file byte in per cycle while the byte queue is not full,
// zero or one event out per byte. The parser state machine takes one byte per cycle while
// the byte queue holds one and the event queue is not full. An accepted byte is registered in
// the byte queue; the parser then writes its event, if any, into the event queue for popping.
// Synchronous active-low reset empties both queues and puts the parser in its wait-for-file
// state; bytes before the first start-of-file mark produce no events.
`timescale 1ns / 1ps

module gif_block_stream_parser #(
    parameter int P_QUEUE_DEPTH = gbp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_event_kind,
    output logic [15:0] o_event_value,
    output logic [9:0]  o_palette_offset,
    output logic [1:0]  o_error_code
);

    localparam int FW = $bits(gbp_pkg::t_front_word);
    localparam int EW = $bits(gbp_pkg::t_event);

    gbp_pkg::t_front_word front_word;
    gbp_pkg::t_front_word back_word;
    gbp_pkg::t_event      back_event;
    gbp_pkg::t_event      out_event;
    logic                 front_push;
    logic                 word_empty;
    logic                 back_pop;
    logic                 ev_valid;
    logic                 ev_full;
    logic [FW-1:0]        word_q;
    logic [EW-1:0]        event_q;

    gbp_front u_front (
        .i_data_byte_v   (push),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_queue_full    (full),
        .o_push          (front_push),
        .o_word          (front_word)
    );

    gbp_queue #(
        .P_WIDTH (FW),
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_word_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_word),
        .o_full  (full),
        .i_pop   (back_pop),
        .o_data  (word_q),
        .o_empty (word_empty)
    );

    assign back_word = word_q;

    gbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!word_empty),
        .i_word     (back_word),
        .o_pop      (back_pop),
        .i_out_full (ev_full),
        .o_ev_valid (ev_valid),
        .o_event    (back_event)
    );

    gbp_queue #(
        .P_WIDTH (EW),
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_event_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_valid),
        .i_data  (back_event),
        .o_full  (ev_full),
        .i_pop   (pop),
        .o_data  (event_q),
        .o_empty (empty)
    );

    assign out_event        = event_q;
    assign o_event_kind     = out_event.kind;
    assign o_event_value    = out_event.value;
    assign o_palette_offset = out_event.offset;
    assign o_error_code     = out_event.err;

endmodule

/* rtl/core/gbp_queue.sv */
// Small register-based first-in first-out queue used between the parser stages.
`timescale 1ns / 1ps

module gbp_queue #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = gbp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic [P_WIDTH-1:0] o_data,
    output logic               o_empty
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [AW-1:0]      r_wr;
    logic [AW-1:0]      r_rd;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      n_wr;
    logic [AW-1:0]      n_rd;
    logic [CW-1:0]      n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* rtl/core/gbp_front.sv */
// Front end: compares each incoming byte against zero and the block, extension, size and loop-id codes.
`timescale 1ns / 1ps

module gbp_front (
    input  logic                 i_data_byte_v,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_start_of_file,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output gbp_pkg::t_front_word o_word
);

    assign o_push = i_data_byte_v && !i_queue_full;

    always_comb begin
        o_word.data            = i_data_byte;
        o_word.sof             = i_start_of_file;
        o_word.cls.is_zero     = (i_data_byte == 8'h00);
        o_word.cls.is_trailer  = (i_data_byte == gbp_pkg::BYTE_TRAILER);
        o_word.cls.is_image    = (i_data_byte == gbp_pkg::BYTE_IMAGE);
        o_word.cls.is_ext      = (i_data_byte == gbp_pkg::BYTE_EXT);
        o_word.cls.is_app      = (i_data_byte == gbp_pkg::BYTE_APP);
        o_word.cls.is_gce      = (i_data_byte == gbp_pkg::BYTE_GCE);
        o_word.cls.is_gce_size = (i_data_byte == gbp_pkg::BYTE_GCE_SIZE);
        o_word.cls.is_app_size = (i_data_byte == gbp_pkg::BYTE_APP_SIZE);
        o_word.cls.is_loop_id  = (i_data_byte == gbp_pkg::BYTE_LOOP_ID);
    end

endmodule

/* rtl/core/gbp_back.sv */
// Back end: the block parser state machine, one classified byte per cycle while not stalled.
`timescale 1ns / 1ps

module gbp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  gbp_pkg::t_front_word i_word,
    output logic                 o_pop,
    input  logic                 i_out_full,
    output logic                 o_ev_valid,
    output gbp_pkg::t_event      o_event
);

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_HEADER    = 5'd1;
    localparam logic [4:0] PH_LSD       = 5'd2;
    localparam logic [4:0] PH_GPAL      = 5'd3;
    localparam logic [4:0] PH_BLOCK     = 5'd4;
    localparam logic [4:0] PH_DESC      = 5'd5;
    localparam logic [4:0] PH_LPAL      = 5'd6;
    localparam logic [4:0] PH_MINCODE   = 5'd7;
    localparam logic [4:0] PH_LZW_SIZE  = 5'd8;
    localparam logic [4:0] PH_LZW_DATA  = 5'd9;
    localparam logic [4:0] PH_EXT_LABEL = 5'd10;
    localparam logic [4:0] PH_SKIP_SIZE = 5'd11;
    localparam logic [4:0] PH_SKIP_DATA = 5'd12;
    localparam logic [4:0] PH_GCE_SIZE  = 5'd13;
    localparam logic [4:0] PH_GCE_DATA  = 5'd14;
    localparam logic [4:0] PH_GCE_TERM  = 5'd15;
    localparam logic [4:0] PH_APP_SIZE  = 5'd16;
    localparam logic [4:0] PH_APP_ID    = 5'd17;
    localparam logic [4:0] PH_APP_SSIZE = 5'd18;
    localparam logic [4:0] PH_APP_SDATA = 5'd19;
    localparam logic [4:0] PH_DONE      = 5'd20;
    localparam logic [4:0] PH_ERROR     = 5'd21;

    logic [4:0] r_phase, n_phase;
    logic [9:0] r_count, n_count;
    logic [7:0] r_low, n_low;
    logic [9:0] r_pal_off, n_pal_off;
    logic       r_app_match, n_app_match;
    logic [1:0] r_app_cnt, n_app_cnt;
    logic       r_app_first, n_app_first;
    logic [7:0] r_flags, n_flags;

    logic        fire;
    logic [7:0]  b;
    logic [15:0] word;
    logic [9:0]  cnt_dec;
    logic [9:0]  cnt_inc;
    logic [9:0]  pal_size;

    assign fire    = i_valid && !i_out_full;
    assign o_pop   = fire;
    assign b       = i_word.data;
    assign word    = {b, r_low};
    assign cnt_dec = r_count - 10'd1;
    assign cnt_inc = r_count + 10'd1;
    // Palette length is three bytes per entry, 2^(n+1) entries.
    assign pal_size = 10'd3 << ({1'b0, b[2:0]} + 4'd1);

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_low       = r_low;
        n_pal_off   = r_pal_off;
        n_app_match = r_app_match;
        n_app_cnt   = r_app_cnt;
        n_app_first = r_app_first;
        n_flags     = r_flags;
        o_ev_valid  = 1'b0;
        o_event     = '0;

        if (fire) begin
            if (i_word.sof) begin
                n_phase     = PH_HEADER;
                n_count     = 10'd5;
                n_low       = '0;
                n_pal_off   = '0;
                n_app_match = 1'b1;
                n_app_cnt   = '0;
                n_app_first = 1'b0;
                n_flags     = '0;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        n_count = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_phase = PH_LSD;
                        end
                    end
                    PH_LSD: begin
                        n_count = cnt_inc;
                        if (r_count == 10'd0 || r_count == 10'd2) begin
                            n_low = b;
                        end else if (r_count == 10'd1) begin
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_SCR_W;
                            o_event.value = word;
                        end else if (r_count == 10'd3) begin
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_SCR_H;
                            o_event.value = word;
                        end else if (r_count == 10'd4) begin
                            n_flags       = b;
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_SCR_FLAGS;
                            o_event.value = {8'd0, b};
                        end else if (r_count >= 10'd6) begin
                            n_pal_off = '0;
                            if (r_flags[7]) begin
                                n_phase = PH_GPAL;
                                n_count = 10'd3 << ({1'b0, r_flags[2:0]} + 4'd1);
                            end else begin
                                n_phase = PH_BLOCK;
                                n_count = '0;
                            end
                        end
                    end
                    PH_GPAL, PH_LPAL: begin
                        n_pal_off      = r_pal_off + 10'd1;
                        n_count        = cnt_dec;
                        o_ev_valid     = 1'b1;
                        o_event.kind   = (r_phase == PH_GPAL) ? gbp_pkg::EV_GPAL
                                                              : gbp_pkg::EV_LPAL;
                        o_event.value  = {8'd0, b};
                        o_event.offset = r_pal_off;
                        if (cnt_dec == '0) begin
                            n_phase = (r_phase == PH_GPAL) ? PH_BLOCK : PH_MINCODE;
                        end
                    end
                    PH_BLOCK: begin
                        n_count = '0;
                        priority if (i_word.cls.is_trailer) begin
                            n_phase      = PH_DONE;
                            o_ev_valid   = 1'b1;
                            o_event.kind = gbp_pkg::EV_TRAILER;
                        end else if (i_word.cls.is_image) begin
                            n_phase = PH_DESC;
                        end else if (i_word.cls.is_ext) begin
                            n_phase = PH_EXT_LABEL;
                        end else if (i_word.cls.is_app) begin
                            n_phase = PH_APP_SIZE;
                        end else begin
                            n_phase       = PH_ERROR;
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_ERROR;
                            o_event.value = {8'd0, b};
                            o_event.err   = gbp_pkg::ERR_UNKNOWN;
                        end
                    end
                    PH_DESC: begin
                        n_count = cnt_inc;
                        if (r_count < 10'd8) begin
                            if (!r_count[0]) begin
                                n_low = b;
                            end else begin
                                o_ev_valid    = 1'b1;
                                o_event.kind  = gbp_pkg::EV_LEFT + {3'd0, r_count[2:1]};
                                o_event.value = word;
                            end
                        end else begin
                            n_flags       = b;
                            n_pal_off     = '0;
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_IMG_FLAGS;
                            o_event.value = {8'd0, b};
                            if (b[7]) begin
                                n_phase = PH_LPAL;
                                n_count = pal_size;
                            end else begin
                                n_phase = PH_MINCODE;
                                n_count = '0;
                            end
                        end
                    end
                    PH_MINCODE: begin
                        n_phase       = PH_LZW_SIZE;
                        o_ev_valid    = 1'b1;
                        o_event.kind  = gbp_pkg::EV_MIN_CODE;
                        o_event.value = {8'd0, b};
                    end
                    PH_LZW_SIZE: begin
                        if (i_word.cls.is_zero) begin
                            n_phase      = PH_BLOCK;
                            o_ev_valid   = 1'b1;
                            o_event.kind = gbp_pkg::EV_IMG_END;
                        end else begin
                            n_count = {2'd0, b};
                            n_phase = PH_LZW_DATA;
                        end
                    end
                    PH_LZW_DATA: begin
                        n_count       = cnt_dec;
                        o_ev_valid    = 1'b1;
                        o_event.kind  = gbp_pkg::EV_LZW_BYTE;
                        o_event.value = {8'd0, b};
                        if (cnt_dec == '0) begin
                            n_phase = PH_LZW_SIZE;
                        end
                    end
                    PH_EXT_LABEL: begin
                        priority if (i_word.cls.is_gce) begin
                            n_phase = PH_GCE_SIZE;
                        end else if (i_word.cls.is_app) begin
                            n_phase = PH_APP_SIZE;
                        end else begin
                            n_phase = PH_SKIP_SIZE;
                        end
                    end
                    PH_SKIP_SIZE, PH_APP_SSIZE: begin
                        if (i_word.cls.is_zero) begin
                            n_phase = PH_BLOCK;
                        end else begin
                            n_count = {2'd0, b};
                            n_phase = (r_phase == PH_SKIP_SIZE) ? PH_SKIP_DATA
                                                                : PH_APP_SDATA;
                        end
                    end
                    PH_SKIP_DATA: begin
                        n_count = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_phase = PH_SKIP_SIZE;
                        end
                    end
                    PH_GCE_SIZE: begin
                        if (!i_word.cls.is_gce_size) begin
                            n_phase       = PH_ERROR;
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_ERROR;
                            o_event.value = {8'd0, b};
                            o_event.err   = gbp_pkg::ERR_GCE_SIZE;
                        end else begin
                            n_count = '0;
                            n_phase = PH_GCE_DATA;
                        end
                    end
                    PH_GCE_DATA: begin
                        n_count = cnt_inc;
                        if (r_count == 10'd0) begin
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_GCE_FLAGS;
                            o_event.value = {8'd0, b};
                        end else if (r_count == 10'd1) begin
                            n_low = b;
                        end else if (r_count == 10'd2) begin
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_DELAY;
                            o_event.value = word;
                        end else begin
                            n_phase       = PH_GCE_TERM;
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_TRANSP;
                            o_event.value = {8'd0, b};
                        end
                    end
                    PH_GCE_TERM: begin
                        if (!i_word.cls.is_zero) begin
                            n_phase       = PH_ERROR;
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_ERROR;
                            o_event.value = {8'd0, b};
                            o_event.err   = gbp_pkg::ERR_GCE_TERM;
                        end else begin
                            n_phase = PH_BLOCK;
                        end
                    end
                    PH_APP_SIZE: begin
                        if (!i_word.cls.is_app_size) begin
                            n_phase       = PH_ERROR;
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_ERROR;
                            o_event.value = {8'd0, b};
                            o_event.err   = gbp_pkg::ERR_APP_SIZE;
                        end else begin
                            n_app_match = 1'b1;
                            n_app_cnt   = '0;
                            n_app_first = 1'b0;
                            n_count     = '0;
                            n_phase     = PH_APP_ID;
                        end
                    end
                    PH_APP_ID: begin
                        if (r_count < 10'd8 && b != gbp_pkg::netscape_char(r_count[2:0])) begin
                            n_app_match = 1'b0;
                        end
                        n_count = cnt_inc;
                        if (r_count >= 10'd10) begin
                            n_count = '0;
                            n_phase = PH_APP_SSIZE;
                        end
                    end
                    PH_APP_SDATA: begin
                        // Data bytes are counted across sub-blocks; the loop count is reported
                        // when the third one arrives, if the ID matched and the first was 01.
                        if (r_app_cnt == 2'd0) begin
                            n_app_first = i_word.cls.is_loop_id;
                        end else if (r_app_cnt == 2'd1) begin
                            n_low = b;
                        end else if (r_app_cnt == 2'd2 && r_app_match && r_app_first) begin
                            o_ev_valid    = 1'b1;
                            o_event.kind  = gbp_pkg::EV_LOOP;
                            o_event.value = word;
                        end
                        if (r_app_cnt != 2'd3) begin
                            n_app_cnt = r_app_cnt + 2'd1;
                        end
                        n_count = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_phase = PH_APP_SSIZE;
                        end
                    end
                    default: begin
                        // Idle, done and error phases ignore bytes until a file start.
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_low       <= '0;
            r_pal_off   <= '0;
            r_app_match <= 1'b1;
            r_app_cnt   <= '0;
            r_app_first <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_low       <= n_low;
            r_pal_off   <= n_pal_off;
            r_app_match <= n_app_match;
            r_app_cnt   <= n_app_cnt;
            r_app_first <= n_app_first;
            r_flags     <= n_flags;
        end
    end

endmodule
